// File: rtl/core/fnms_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fnms_pkg: shared types and constants for fast NMS box suppression
// Field widths, register codes and reset values, stored entry layout.
// ----------------------------------------------------------------------------
package fnms_pkg;

   localparam int COORD_W      = 24;
   localparam int AREA_W       = 48;
   localparam int UNI_W        = AREA_W + 1;
   localparam int THR_W        = 16;
   localparam int MAXDET_W     = 11;
   localparam int SLOT_W       = 10;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 16;
   // multiplier is 25 x 24; the threshold product is built from two halves of union
   localparam int MUL_A_W      = COORD_W + 1;
   localparam int MUL_B_W      = COORD_W;
   localparam int PROD_W       = MUL_A_W + MUL_B_W;
   localparam int UNI_LO_W     = MUL_A_W;
   localparam int UNI_HI_W     = UNI_W - UNI_LO_W;
   localparam int CMP_W        = PROD_W + UNI_LO_W;
   localparam int MAX_BOXES_DEF = 1024;

   localparam logic [THR_W-1:0]    THR_RESET    = 16'd29491;
   localparam logic [MAXDET_W-1:0] MAXDET_RESET = 11'd100;

   localparam logic [CSR_IDX_W-1:0] CSR_IOU_THRESHOLD  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DETECTIONS = 2'd1;

   typedef struct packed {
      logic signed [COORD_W-1:0] left;
      logic signed [COORD_W-1:0] top;
      logic signed [COORD_W-1:0] right;
      logic signed [COORD_W-1:0] bottom;
      logic [AREA_W-1:0]         area;
   } box_entry_type;

   // extent hi - lo, clamped at zero
   function automatic logic [COORD_W-1:0] span(input logic signed [COORD_W-1:0] lo,
                                                 input logic signed [COORD_W-1:0] hi);
      logic signed [COORD_W:0] diff;
      diff = {hi[COORD_W-1], hi} - {lo[COORD_W-1], lo};
      return (hi > lo) ? diff[COORD_W-1:0] : '0;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/fnms_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fnms_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fnms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/fast_nms_box_suppression.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fast_nms_box_suppression: fast non-maximum suppression, one box per word
// Each box is checked against every earlier box of its set by exact IoU
// compare (inter*65536 < thr*union) through one shared multiplier.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req_    | in        | start & !busy      | box_left/top/right/bottom, end_of_set
//  rsp_    | out       | rsp_valid, 1 cycle | keep, kept_slot, set_done
//  csr_    | in        | csr_wr_en          | csr_index, csr_wdata
//
// Busy stays high while a word is scanned against the earlier boxes of the
// set, so no new word is taken until its result is out; a zero-union pair
// skips the threshold products and the scan stops at the first box that
// suppresses the word. Zero threshold or an empty set skip the scan; a word
// on a full store goes straight to S_FIN and is dropped. The scan is paced by the shared
// multiplier, used three times per stored box (intersection, then threshold
// times the low and high halves of union), and the store's single read port.
// The result is strobed from the registers that S_FIN loads; busy drops at the same time.
// Reset clears counts and loads the config reset values; the box store needs no clearing.
// The receiver cannot stall: each result is shown for one cycle only.
// ----------------------------------------------------------------------------
module fast_nms_box_suppression #(
   parameter int MAX_BOXES = fnms_pkg::MAX_BOXES_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic signed [fnms_pkg::COORD_W-1:0] req_box_left,
   input  wire logic signed [fnms_pkg::COORD_W-1:0] req_box_top,
   input  wire logic signed [fnms_pkg::COORD_W-1:0] req_box_right,
   input  wire logic signed [fnms_pkg::COORD_W-1:0] req_box_bottom,
   input  wire logic                                req_end_of_set,
   output logic                                     rsp_valid,
   output logic                                     rsp_keep,
   output logic [fnms_pkg::SLOT_W-1:0]              rsp_kept_slot,
   output logic                                     rsp_set_done,
   input  wire logic                                csr_wr_en,
   input  wire logic [fnms_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [fnms_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int ADDR_W = $clog2(MAX_BOXES);
   localparam int CNT_W  = $clog2(MAX_BOXES + 1);
   localparam int KW     = (CNT_W > fnms_pkg::MAXDET_W) ? CNT_W : fnms_pkg::MAXDET_W;
   localparam int CW     = fnms_pkg::COORD_W;

   typedef enum logic [3:0] {
      S_IDLE, S_ASPAN, S_AMUL, S_AREA, S_RD, S_ISPAN, S_IMUL, S_UNI, S_TLO,
      S_THI, S_CMP, S_FIN
   } state_type;

   state_type state_ff, state_in;

   // config
   logic [fnms_pkg::THR_W-1:0]    thr_ff;
   logic [fnms_pkg::MAXDET_W-1:0] maxdet_ff;

   // counts and scan index
   logic [CNT_W-1:0] stored_ff, stored_in;
   logic [CNT_W-1:0] kept_ff, kept_in;
   logic [CNT_W-1:0] idx_ff, idx_in;

   // current word
   fnms_pkg::box_entry_type cur_ff, cur_in;
   logic eos_ff, eos_in;
   logic drop_ff, drop_in;
   logic pass_ff, pass_in;

   // shared multiplier: operands and registered product
   logic [fnms_pkg::MUL_A_W-1:0] mul_a_ff, mul_a_in;
   logic [fnms_pkg::MUL_B_W-1:0] mul_b_ff, mul_b_in;
   logic [fnms_pkg::PROD_W-1:0]  prod_ff;

   logic [fnms_pkg::AREA_W-1:0]   inter_ff, inter_in;
   logic [fnms_pkg::AREA_W-1:0]   other_area_ff, other_area_in;
   logic [fnms_pkg::UNI_HI_W-1:0] uni_hi_ff, uni_hi_in;
   logic [fnms_pkg::PROD_W-1:0]   plo_ff, plo_in;

   // result
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_keep_ff, rsp_keep_in;
   logic [fnms_pkg::SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic                        rsp_done_ff, rsp_done_in;

   // store
   fnms_pkg::box_entry_type rd_entry;
   logic                    ram_rd_en, ram_wr_en;

   fnms_ram #(
      .WIDTH ($bits(fnms_pkg::box_entry_type)),
      .DEPTH (MAX_BOXES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (stored_ff[ADDR_W-1:0]),
      .wr_data (cur_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (rd_entry)
   );

   assign ram_rd_en = (state_ff == S_RD);
   assign ram_wr_en = (state_ff == S_FIN) && !drop_ff;

   // intersection edges against the stored box
   logic signed [CW-1:0] il, ir, it, ib;
   assign il = (cur_ff.left   > rd_entry.left)   ? cur_ff.left   : rd_entry.left;
   assign ir = (cur_ff.right  < rd_entry.right)  ? cur_ff.right  : rd_entry.right;
   assign it = (cur_ff.top    > rd_entry.top)    ? cur_ff.top    : rd_entry.top;
   assign ib = (cur_ff.bottom < rd_entry.bottom) ? cur_ff.bottom : rd_entry.bottom;

   logic [fnms_pkg::UNI_W-1:0]  area_sum;
   logic [fnms_pkg::UNI_W-1:0]  inter_wide;
   logic [fnms_pkg::UNI_W-1:0]  uni_w;
   logic [fnms_pkg::CMP_W-1:0]  lhs, rhs;
   logic [KW-1:0]               kept_ext, maxdet_ext;
   logic [31:0]                 kept32;
   logic [CNT_W-1:0]            idx_next;

   assign area_sum   = {1'b0, cur_ff.area} + {1'b0, other_area_ff};
   assign inter_wide = {1'b0, prod_ff[fnms_pkg::AREA_W-1:0]};
   assign uni_w      = area_sum - inter_wide;
   assign lhs        = fnms_pkg::CMP_W'({inter_ff, 16'b0});
   // thr*union = (thr*hi << 25) + thr*lo; high half is in prod_ff at S_CMP
   assign rhs        = {prod_ff, {fnms_pkg::UNI_LO_W{1'b0}}} + fnms_pkg::CMP_W'(plo_ff);
   assign kept_ext   = KW'(kept_ff);
   assign maxdet_ext = KW'(maxdet_ff);
   assign kept32     = 32'(kept_ff);
   assign idx_next   = idx_ff + 1'b1;

   always_comb begin
      state_in      = state_ff;
      stored_in     = stored_ff;
      kept_in       = kept_ff;
      idx_in        = idx_ff;
      cur_in        = cur_ff;
      eos_in        = eos_ff;
      drop_in       = drop_ff;
      pass_in       = pass_ff;
      mul_a_in      = mul_a_ff;
      mul_b_in      = mul_b_ff;
      inter_in      = inter_ff;
      other_area_in = other_area_ff;
      uni_hi_in     = uni_hi_ff;
      plo_in        = plo_ff;
      rsp_valid_in  = 1'b0;
      rsp_keep_in   = rsp_keep_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_done_in   = rsp_done_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cur_in.left   = req_box_left;
               cur_in.top    = req_box_top;
               cur_in.right  = req_box_right;
               cur_in.bottom = req_box_bottom;
               eos_in        = req_end_of_set;
               drop_in       = (stored_ff == CNT_W'(MAX_BOXES));
               pass_in       = (thr_ff != '0);
               idx_in        = '0;
               state_in      = (stored_ff == CNT_W'(MAX_BOXES)) ? S_FIN : S_ASPAN;
            end
         end
         S_ASPAN: begin
            mul_a_in = fnms_pkg::MUL_A_W'(fnms_pkg::span(cur_ff.left, cur_ff.right));
            mul_b_in = fnms_pkg::span(cur_ff.top, cur_ff.bottom);
            state_in = S_AMUL;
         end
         S_AMUL: state_in = S_AREA;
         S_AREA: begin
            cur_in.area = prod_ff[fnms_pkg::AREA_W-1:0];
            // zero threshold keeps nothing: no need to scan
            state_in = (stored_ff == '0 || !pass_ff) ? S_FIN : S_RD;
         end
         S_RD: state_in = S_ISPAN;
         S_ISPAN: begin
            mul_a_in      = fnms_pkg::MUL_A_W'(fnms_pkg::span(il, ir));
            mul_b_in      = fnms_pkg::span(it, ib);
            other_area_in = rd_entry.area;
            state_in      = S_IMUL;
         end
         S_IMUL: state_in = S_UNI;
         S_UNI: begin
            inter_in  = prod_ff[fnms_pkg::AREA_W-1:0];
            mul_a_in  = uni_w[fnms_pkg::UNI_LO_W-1:0];
            mul_b_in  = fnms_pkg::MUL_B_W'(thr_ff);
            uni_hi_in = uni_w[fnms_pkg::UNI_W-1:fnms_pkg::UNI_LO_W];
            if (area_sum <= inter_wide) begin
               // zero union: no overlap
               idx_in   = idx_next;
               state_in = (idx_next == stored_ff) ? S_FIN : S_RD;
            end else begin
               state_in = S_TLO;
            end
         end
         S_TLO: begin
            mul_a_in = fnms_pkg::MUL_A_W'(uni_hi_ff);
            state_in = S_THI;
         end
         S_THI: begin
            plo_in   = prod_ff;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (!(lhs < rhs)) begin
               pass_in  = 1'b0;
               state_in = S_FIN;
            end else begin
               idx_in   = idx_next;
               state_in = (idx_next == stored_ff) ? S_FIN : S_RD;
            end
         end
         S_FIN: begin
            rsp_valid_in = 1'b1;
            rsp_done_in  = eos_ff;
            rsp_keep_in  = 1'b0;
            rsp_slot_in  = '0;
            if (!drop_ff) begin
               stored_in = stored_ff + 1'b1;
               if (pass_ff && kept_ext < maxdet_ext) begin
                  rsp_keep_in = 1'b1;
                  rsp_slot_in = kept32[fnms_pkg::SLOT_W-1:0];
                  kept_in     = kept_ff + 1'b1;
               end
            end
            if (eos_ff) begin
               stored_in = '0;
               kept_in   = '0;
            end
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff       <= mul_a_ff * mul_b_ff;
      mul_a_ff      <= mul_a_in;
      mul_b_ff      <= mul_b_in;
      cur_ff        <= cur_in;
      eos_ff        <= eos_in;
      drop_ff       <= drop_in;
      pass_ff       <= pass_in;
      inter_ff      <= inter_in;
      other_area_ff <= other_area_in;
      uni_hi_ff     <= uni_hi_in;
      plo_ff        <= plo_in;
      idx_ff        <= idx_in;
      rsp_keep_ff   <= rsp_keep_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_done_ff   <= rsp_done_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         stored_ff    <= '0;
         kept_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         thr_ff       <= fnms_pkg::THR_RESET;
         maxdet_ff    <= fnms_pkg::MAXDET_RESET;
      end else begin
         state_ff     <= state_in;
         stored_ff    <= stored_in;
         kept_ff      <= kept_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en && csr_index == fnms_pkg::CSR_IOU_THRESHOLD) begin
            thr_ff <= csr_wdata;
         end
         if (csr_wr_en && csr_index == fnms_pkg::CSR_MAX_DETECTIONS) begin
            maxdet_ff <= csr_wdata[fnms_pkg::MAXDET_W-1:0];
         end
      end
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_keep      = rsp_keep_ff;
   assign rsp_kept_slot = rsp_slot_ff;
   assign rsp_set_done  = rsp_done_ff;

endmodule
`default_nettype wire

// File: tb/fast_nms_box_suppression_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fast_nms_box_suppression_tb: self-checking bench for fast NMS suppression
// Drives candidate boxes in sets, predicts keep/slot/set_done per word with
// an exact IoU product compare, and checks every result strobe in order.
// ----------------------------------------------------------------------------
module fast_nms_box_suppression_tb;

   localparam int CAPACITY    = fnms_pkg::MAX_BOXES_DEF;
   localparam int CYCLE_LIMIT = 2_000_000;

   typedef logic signed [fnms_pkg::COORD_W-1:0] coord_type;

   typedef struct packed {
      logic                        keep;
      logic [fnms_pkg::SLOT_W-1:0] slot;
      logic                        done;
   } verdict_type;

   // ------------------------------------------------------------------------
   // scoreboard: own copy of box store, counts and registers
   // ------------------------------------------------------------------------
   class nms_scoreboard;
      coord_type                     lf [CAPACITY];
      coord_type                     tp [CAPACITY];
      coord_type                     rt [CAPACITY];
      coord_type                     bt [CAPACITY];
      logic [fnms_pkg::AREA_W-1:0]   ar [CAPACITY];
      int unsigned                   n_stored;
      int unsigned                   n_kept;
      logic [fnms_pkg::THR_W-1:0]    thr;
      logic [fnms_pkg::MAXDET_W-1:0] max_det;
      verdict_type                   verdicts [$];
      int unsigned                   mismatches;
      int unsigned                   checked;
      int unsigned                   kept_total;

      function new();
         n_stored = 0;
         n_kept   = 0;
         thr      = fnms_pkg::THR_RESET;
         max_det  = fnms_pkg::MAXDET_RESET;
         mismatches = 0;
         checked    = 0;
         kept_total = 0;
      endfunction

      function void write_reg(logic [fnms_pkg::CSR_IDX_W-1:0] idx,
                              logic [fnms_pkg::CSR_DATA_W-1:0] val);
         if (idx == fnms_pkg::CSR_IOU_THRESHOLD)
            thr = val[fnms_pkg::THR_W-1:0];
         else if (idx == fnms_pkg::CSR_MAX_DETECTIONS)
            max_det = val[fnms_pkg::MAXDET_W-1:0];
      endfunction

      // extent hi - lo, clamped at zero
      function logic [fnms_pkg::COORD_W-1:0] extent(coord_type lo, coord_type hi);
         logic signed [fnms_pkg::COORD_W:0] d;
         d = {hi[fnms_pkg::COORD_W-1], hi} - {lo[fnms_pkg::COORD_W-1], lo};
         return (hi > lo) ? d[fnms_pkg::COORD_W-1:0] : '0;
      endfunction

      function void note_word(coord_type l, coord_type t, coord_type r, coord_type b,
                              logic eos);
         verdict_type                 v;
         logic [fnms_pkg::AREA_W-1:0] area, inter;
         logic [fnms_pkg::AREA_W:0]   sum, uni;
         logic [79:0]                 lhs, rhs;
         coord_type                   il, ir, it, ib;
         bit                          pass;
         v = '0;
         v.done = eos;
         if (n_stored < CAPACITY) begin
            area = fnms_pkg::AREA_W'(extent(l, r)) * fnms_pkg::AREA_W'(extent(t, b));
            pass = (thr != 0);
            for (int c = 0; c < n_stored; c++) begin
               il = (l > lf[c]) ? l : lf[c];
               ir = (r < rt[c]) ? r : rt[c];
               it = (t > tp[c]) ? t : tp[c];
               ib = (b < bt[c]) ? b : bt[c];
               inter = fnms_pkg::AREA_W'(extent(il, ir)) * fnms_pkg::AREA_W'(extent(it, ib));
               sum = {1'b0, area} + {1'b0, ar[c]};
               if (sum <= {1'b0, inter})
                  continue;   // zero union counts as no overlap
               uni = sum - {1'b0, inter};
               lhs = 80'(inter) << 16;
               rhs = 80'(thr) * 80'(uni);
               if (!(lhs < rhs)) begin
                  pass = 0;
                  break;
               end
            end
            lf[n_stored] = l;
            tp[n_stored] = t;
            rt[n_stored] = r;
            bt[n_stored] = b;
            ar[n_stored] = area;
            n_stored++;
            if (pass && n_kept < max_det) begin
               v.keep = 1'b1;
               v.slot = fnms_pkg::SLOT_W'(n_kept);
               n_kept++;
            end
         end
         verdicts.push_back(v);
         if (eos) begin
            n_stored = 0;
            n_kept   = 0;
         end
      endfunction

      function void check_result(logic keep, logic [fnms_pkg::SLOT_W-1:0] slot, logic done);
         verdict_type e;
         checked++;
         if (verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: result with nothing expected (keep=%0d slot=%0d done=%0d)",
                        keep, slot, done);
            return;
         end
         e = verdicts.pop_front();
         if (keep) kept_total++;
         if (e.keep !== keep || e.slot !== slot || e.done !== done) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: keep %0d/%0d slot %0d/%0d set_done %0d/%0d (exp/act)",
                        e.keep, keep, e.slot, slot, e.done, done);
         end
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // clock, reset, block
   // ------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   coord_type box_l = '0, box_t = '0, box_r = '0, box_b = '0;
   logic   box_eos = 1'b0;
   logic   rsp_valid, rsp_keep, rsp_set_done;
   logic [fnms_pkg::SLOT_W-1:0] rsp_kept_slot;
   logic   csr_wr_en = 1'b0;
   logic [fnms_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [fnms_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   nms_scoreboard sb = new();
   int unsigned   cycles = 0;
   int unsigned   words_sent = 0;
   int unsigned   burst_left = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   fast_nms_box_suppression dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_box_left   (box_l),
      .req_box_top    (box_t),
      .req_box_right  (box_r),
      .req_box_bottom (box_b),
      .req_end_of_set (box_eos),
      .rsp_valid      (rsp_valid),
      .rsp_keep       (rsp_keep),
      .rsp_kept_slot  (rsp_kept_slot),
      .rsp_set_done   (rsp_set_done),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // monitor: note accepted words, check strobed results
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            sb.note_word(box_l, box_t, box_r, box_b, box_eos);
         if (rsp_valid)
            sb.check_result(rsp_keep, rsp_kept_slot, rsp_set_done);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("ERROR: timeout after %0d cycles", cycles);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // drive tasks; all called at a rising edge
   // ------------------------------------------------------------------------
   task automatic idle(int unsigned n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // one word; returns at the edge that accepted it, start left high
   task automatic send_box(coord_type l, coord_type t, coord_type r, coord_type b,
                           logic eos);
      box_l   <= l;
      box_t   <= t;
      box_r   <= r;
      box_b   <= b;
      box_eos <= eos;
      start   <= 1'b1;
      do @(posedge clock); while (busy);
      words_sent++;
   endtask

   // bursty sender: random-length bursts, random gaps between them
   task automatic send_paced(coord_type l, coord_type t, coord_type r, coord_type b,
                             logic eos);
      send_box(l, t, r, b, eos);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 3) != 0)
            idle($urandom_range(1, 15));
      end else begin
         burst_left--;
      end
   endtask

   // wait for every expected result, then a short settle
   task automatic drain();
      idle(1);
      while (sb.verdicts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(logic [fnms_pkg::CSR_IDX_W-1:0] idx,
                            logic [fnms_pkg::CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      sb.write_reg(idx, val);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_regs(int unsigned thr, int unsigned det);
      write_reg(fnms_pkg::CSR_IOU_THRESHOLD, fnms_pkg::CSR_DATA_W'(thr));
      write_reg(fnms_pkg::CSR_MAX_DETECTIONS, fnms_pkg::CSR_DATA_W'(det));
   endtask

   // random set: mostly boxes clustered around one spot so IoU lands
   // near the threshold, some fully random noise boxes
   task automatic random_set(int unsigned len);
      coord_type cx, cy, l, t, r, b;
      int        w, h;
      cx = coord_type'($urandom_range(0, 2**22) - 2**21);
      cy = coord_type'($urandom_range(0, 2**22) - 2**21);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) < 2) begin
            l = coord_type'($urandom); t = coord_type'($urandom);
            r = coord_type'($urandom); b = coord_type'($urandom);
         end else begin
            w = $urandom_range(0, 600);
            h = $urandom_range(0, 600);
            l = coord_type'(cx + coord_type'($urandom_range(0, 400)) - 200);
            t = coord_type'(cy + coord_type'($urandom_range(0, 400)) - 200);
            r = l + coord_type'(w);
            b = t + coord_type'(h);
            if ($urandom_range(0, 19) == 0) begin
               r = l - coord_type'(w);   // inverted box
            end
         end
         send_paced(l, t, r, b, i == len - 1);
      end
   endtask

   localparam coord_type CMIN = coord_type'(24'h800000);
   localparam coord_type CMAX = coord_type'(24'h7FFFFF);

   initial begin
      int unsigned thr_list [6];
      int unsigned det_list [6];
      thr_list = '{29491, 65535, 1, 0, 32768, 0};
      det_list = '{100, 1024, 3, 5, 0, 0};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset config: extremes, identical, disjoint, inverted, empty
      send_box(CMIN, CMIN, CMAX, CMAX, 1'b0);
      send_box(CMIN, CMIN, CMAX, CMAX, 1'b0);          // identical, suppressed
      send_box(CMAX, CMAX, CMIN, CMIN, 1'b0);          // inverted, zero area
      send_box(24'sd100, 24'sd100, 24'sd100, 24'sd200, 1'b0); // zero width
      send_box(CMIN, CMIN, coord_type'(CMIN + 16), coord_type'(CMIN + 16), 1'b0);
      send_box(coord_type'(CMAX - 16), coord_type'(CMAX - 16), CMAX, CMAX, 1'b1);
      send_box(24'sd0, 24'sd0, 24'sd160, 24'sd160, 1'b0);
      send_box(24'sd80, 24'sd0, 24'sd240, 24'sd160, 1'b0);  // half overlap
      send_box(24'sd500, 24'sd500, 24'sd600, 24'sd600, 1'b1);
      drain();

      // zero threshold: nothing kept
      set_regs(0, 100);
      send_box(24'sd0, 24'sd0, 24'sd16, 24'sd16, 1'b0);
      send_box(24'sd100, 24'sd100, 24'sd116, 24'sd116, 1'b1);
      drain();

      // no detections allowed, then one; top threshold
      set_regs(65535, 0);
      send_box(24'sd0, 24'sd0, 24'sd16, 24'sd16, 1'b1);
      drain();
      set_regs(65535, 1);
      send_box(24'sd0, 24'sd0, 24'sd16, 24'sd16, 1'b0);
      send_box(24'sd100, 24'sd100, 24'sd116, 24'sd116, 1'b0); // limit reached
      send_box(24'sd0, 24'sd0, 24'sd16, 24'sd16, 1'b0);       // fully covered
      send_box(24'sd1, 24'sd1, 24'sd16, 24'sd16, 1'b1);       // IoU just below 1
      drain();

      // random phases over several register settings
      thr_list[5] = $urandom_range(0, 65535);
      det_list[5] = $urandom_range(0, 1024);
      for (int p = 0; p < 6; p++) begin
         set_regs(thr_list[p], det_list[p]);
         for (int k = 0; k < 90; ) begin
            int unsigned len;
            len = $urandom_range(1, 10);
            random_set(len);
            k += len;
         end
         drain();
      end

      $display("Run covered %0d words, %0d results checked, %0d boxes kept.",
               words_sent, sb.checked, sb.kept_total);
      $display("Sets spanned threshold and detection-limit extremes and edge boxes.");
      if (sb.mismatches == 0 && sb.verdicts.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("ERROR: %0d mismatches, %0d results missing",
                  sb.mismatches, sb.verdicts.size());
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
